// ===== rtl/shc_pkg.sv =====
// shared constants and round functions for the sha-256 hash core
// no dependencies; imported by sha256_hash_core
package shc_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned HashWords  = 8;
   localparam int unsigned WindowLen  = 16;
   localparam int unsigned RoundCount = 64;
   localparam int unsigned ByteCntW   = 61;

   localparam logic [2:0] BytesFull   = 3'd4;
   localparam logic [3:0] LenHiSlot   = 4'd14;
   localparam logic [3:0] LastSlot    = 4'd15;
   localparam logic [5:0] LastRound   = 6'd63;
   localparam logic [2:0] LastDigest  = 3'd7;

   localparam logic [WordWidth-1:0] PadMarkWord = 32'h8000_0000;

   localparam logic [WordWidth-1:0] INIT_HASH [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WordWidth-1:0] ROUND_K [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [WordWidth-1:0] big_sigma0(input logic [WordWidth-1:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WordWidth-1:0] big_sigma1(input logic [WordWidth-1:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WordWidth-1:0] small_sigma0(input logic [WordWidth-1:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WordWidth-1:0] small_sigma1(input logic [WordWidth-1:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// ===== rtl/sha256_hash_core.sv =====
// sha-256 hash core: word intake, padding sequencer, one-round-per-cycle compression
// depends on shc_pkg (constants, round constants, sigma functions)
//
// usage
//  req channel: one big-endian 32-bit word per beat, first byte in bits 31..24.
//  req_valid_bytes counts the leading valid bytes and only matters with
//  req_message_end; values above 4 act as 4, and 0 ends the message before
//  the word. bytes past the valid ones are ignored.
//  rsp channel: eight digest words per message, rsp_word_index 0 (H0) to 7,
//  rsp_last_word set on the eighth.
// flow
//  an ordinary word goes straight into the schedule window; the word that fills
//  a 16-word block is followed by 64 rounds in the single round unit and the
//  hash update, and no word is taken until they are done. the end word is
//  followed by up to 17 padding words and one or two block compressions, then
//  eight digest beats.
// reset clears the sequencer, byte count and block position and loads the
// initial hash. while digest beats wait on rsp_ready the core holds them and
// takes no new word; the next message starts after the last beat.
module sha256_hash_core
   import shc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WordWidth-1:0] req_data_word,
   input  logic [2:0]           req_valid_bytes,
   input  logic                 req_message_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WordWidth-1:0] rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_MARK,
      PH_ZERO,
      PH_LEN_LO,
      PH_DONE
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [3:0]            wib_ff, wib_in;
   logic [5:0]            round_ff, round_in;
   logic [2:0]            idx_ff, idx_in;
   logic [ByteCntW-1:0]   bytes_ff, bytes_in;
   logic [WordWidth-1:0]  hash_ff [HashWords];
   logic [WordWidth-1:0]  vars_ff [HashWords];
   logic [WordWidth-1:0]  window_ff [WindowLen];

   logic                  push_en;
   logic [WordWidth-1:0]  push_data;
   logic                  load_vars;
   logic                  hash_update;
   logic                  hash_restart;
   logic [2:0]            end_bytes;
   logic [WordWidth-1:0]  end_word;
   logic [WordWidth-1:0]  t1;
   logic [WordWidth-1:0]  t2;
   logic [WordWidth-1:0]  sched_next;
   logic [WordWidth-1:0]  len_hi;
   logic [WordWidth-1:0]  len_lo;

   assign end_bytes = (req_valid_bytes > BytesFull) ? BytesFull : req_valid_bytes;
   assign len_hi    = bytes_ff[60:29];
   assign len_lo    = {bytes_ff[28:0], 3'b000};

   // keep the valid bytes and drop the pad marker after them; a full word stays as is
   always_comb begin
      unique case (end_bytes)
         3'd0:    end_word = PadMarkWord;
         3'd1:    end_word = {req_data_word[31:24], 24'h80_0000};
         3'd2:    end_word = {req_data_word[31:16], 16'h8000};
         3'd3:    end_word = {req_data_word[31:8], 8'h80};
         default: end_word = req_data_word;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      wib_in       = wib_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      bytes_in     = bytes_ff;
      push_en      = 1'b0;
      push_data    = '0;
      load_vars    = 1'b0;
      hash_update  = 1'b0;
      hash_restart = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push_en = 1'b1;
               if (!req_message_end) begin
                  push_data = req_data_word;
                  bytes_in  = bytes_ff + ByteCntW'(BytesFull);
               end else begin
                  push_data = end_word;
                  bytes_in  = bytes_ff + ByteCntW'(end_bytes);
                  phase_in  = (end_bytes == BytesFull) ? PH_MARK : PH_ZERO;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            unique case (phase_ff)
               PH_MARK: begin
                  push_en   = 1'b1;
                  push_data = PadMarkWord;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  push_en = 1'b1;
                  if (wib_ff == LenHiSlot) begin
                     push_data = len_hi;
                     phase_in  = PH_LEN_LO;
                  end
               end
               PH_LEN_LO: begin
                  push_en   = 1'b1;
                  push_data = len_lo;
                  phase_in  = PH_DONE;
               end
               default: begin
                  push_en = 1'b0;
               end
            endcase
         end
         ST_COMPRESS: begin
            round_in = round_ff + 6'd1;
            if (round_ff == LastRound) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            hash_update = 1'b1;
            priority if (phase_ff == PH_DONE) begin
               state_in = ST_OUTPUT;
               idx_in   = '0;
            end else if (phase_ff == PH_NONE) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LastDigest) begin
                  state_in     = ST_IDLE;
                  phase_in     = PH_NONE;
                  bytes_in     = '0;
                  hash_restart = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a full block hands over to the round unit
      if (push_en) begin
         wib_in = wib_ff + 4'd1;
         if (wib_ff == LastSlot) begin
            state_in  = ST_COMPRESS;
            round_in  = '0;
            load_vars = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NONE;
         wib_ff   <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         bytes_ff <= '0;
         for (int i = 0; i < HashWords; i++) begin
            hash_ff[i] <= INIT_HASH[i];
         end
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wib_ff   <= wib_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         bytes_ff <= bytes_in;
         for (int i = 0; i < HashWords; i++) begin
            if (hash_restart) begin
               hash_ff[i] <= INIT_HASH[i];
            end else if (hash_update) begin
               hash_ff[i] <= hash_ff[i] + vars_ff[i];
            end
         end
      end
   end

   // round unit: window_ff[0] is the current schedule word
   assign sched_next = small_sigma1(window_ff[14]) + window_ff[9]
                     + small_sigma0(window_ff[1]) + window_ff[0];
   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + ROUND_K[round_ff] + window_ff[0];
   assign t2 = big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));

   always_ff @(posedge clock) begin
      if (push_en) begin
         for (int i = 0; i < WindowLen - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WindowLen-1] <= push_data;
      end else if (state_ff == ST_COMPRESS) begin
         for (int i = 0; i < WindowLen - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WindowLen-1] <= sched_next;
      end

      if (load_vars) begin
         for (int i = 0; i < HashWords; i++) begin
            vars_ff[i] <= hash_ff[i];
         end
      end else if (state_ff == ST_COMPRESS) begin
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUTPUT);
   assign rsp_digest_word = hash_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == LastDigest);

   // the two channels never run at once
   a_rsp_excludes_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("digest beat offered while words are being taken");

   // digest only after a completed block with the length field in place
   a_output_block_aligned : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUTPUT) |-> (wib_ff == '0 && phase_ff == PH_DONE))
      else $error("digest offered with a partial block");

   a_round_count_end : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPRESS && round_ff == LastRound) |=> (state_ff == ST_UPDATE))
      else $error("compression did not finish after the last round");

   // after the final beat the core starts a fresh message
   a_restart_after_digest : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word)
      |=> (req_ready && bytes_ff == '0 && hash_ff[0] == INIT_HASH[0]))
      else $error("core not restarted after the last digest beat");

endmodule

// ===== tb/sha256_hash_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for sha256_hash_core: directed table, then random messages
// holds its own sha-256 predictor; needs shc_pkg and the core, nothing else
module sha256_hash_core_tb;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   typedef struct packed {
      logic [31:0]  data;
      logic [2:0]   nbytes;
      logic         ends;
      logic         known;
      logic [255:0] digest;
   } msg_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [shc_pkg::WordWidth-1:0] req_data_word;
   logic [2:0] req_valid_bytes;
   logic req_message_end;
   logic rsp_valid;
   logic rsp_ready;
   logic [shc_pkg::WordWidth-1:0] rsp_digest_word;
   logic [2:0] rsp_word_index;
   logic rsp_last_word;

   // predictor state
   logic [31:0] run_hash [8];
   logic [31:0] sched [16];
   logic [3:0]  blk_pos;
   logic [60:0] byte_total;

   digest_beat_type digest_due [$];
   int mismatch_count = 0;
   int items_sent = 0;
   logic calm_send = 1'b0;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] KTAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // empty message, "abc" with junk in the unused byte, lone end words with short and
   // oversized byte counts, a 14-word message whose length spills into an extra block
   msg_row_type dir_rows [23] = '{
      '{32'hffffffff, 3'd0, 1'b1, 1'b1,
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855},
      '{32'h616263a5, 3'd3, 1'b1, 1'b1,
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
      '{32'hffffffff, 3'd1, 1'b1, 1'b0, 256'd0},
      '{32'h00000000, 3'd2, 1'b1, 1'b0, 256'd0},
      '{32'hffffffff, 3'd5, 1'b1, 1'b0, 256'd0},
      '{32'h0000ffff, 3'd6, 1'b1, 1'b0, 256'd0},
      '{32'h12345678, 3'd7, 1'b1, 1'b0, 256'd0},
      '{32'hffffffff, 3'd0, 1'b0, 1'b0, 256'd0},
      '{32'h00000000, 3'd7, 1'b0, 1'b0, 256'd0},
      '{32'hffffffff, 3'd1, 1'b0, 1'b0, 256'd0},
      '{32'h00000000, 3'd2, 1'b0, 1'b0, 256'd0},
      '{32'hffffffff, 3'd3, 1'b0, 1'b0, 256'd0},
      '{32'h00000000, 3'd4, 1'b0, 1'b0, 256'd0},
      '{32'hffffffff, 3'd5, 1'b0, 1'b0, 256'd0},
      '{32'h00000000, 3'd6, 1'b0, 1'b0, 256'd0},
      '{32'haaaaaaaa, 3'd0, 1'b0, 1'b0, 256'd0},
      '{32'h55555555, 3'd7, 1'b0, 1'b0, 256'd0},
      '{32'h80000000, 3'd4, 1'b0, 1'b0, 256'd0},
      '{32'h00000001, 3'd4, 1'b0, 1'b0, 256'd0},
      '{32'hdeadbeef, 3'd4, 1'b0, 1'b0, 256'd0},
      '{32'hffffffff, 3'd4, 1'b1, 1'b0, 256'd0},
      '{32'h01234567, 3'd4, 1'b0, 1'b0, 256'd0},
      '{32'h89abcdef, 3'd3, 1'b1, 1'b0, 256'd0}
   };

   sha256_hash_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_message_end (req_message_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void hash_restart();
      for (int i = 0; i < 8; i++) run_hash[i] = IV[i];
      blk_pos = 4'd0;
      byte_total = '0;
   endfunction

   function automatic void sha_compress();
      logic [31:0] v [8];
      logic [31:0] w2, w15, s0, s1, t1, t2;
      int t;
      for (int i = 0; i < 8; i++) v[i] = run_hash[i];
      for (t = 0; t < 64; t++) begin
         if (t >= 16) begin
            w2  = sched[(t + 14) % 16];
            w15 = sched[(t + 1) % 16];
            s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
            s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
            sched[t % 16] = s1 + sched[(t + 9) % 16] + s0 + sched[t % 16];
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + sched[t % 16];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) run_hash[i] = run_hash[i] + v[i];
   endfunction

   function automatic void sha_absorb(input logic [31:0] w);
      sched[blk_pos] = w;
      blk_pos = blk_pos + 4'd1;
      if (blk_pos == 4'd0) sha_compress();
   endfunction

   // advances the predictor by one accepted beat; a message end queues eight digest beats,
   // taken from the typed-in digest when the row carries one
   function automatic void digest_predict(input logic [31:0] d, input logic [2:0] nb,
                                          input logic ends, input logic known,
                                          input logic [255:0] ref_digest);
      logic [31:0] keep;
      logic [63:0] bit_len;
      digest_beat_type beat;
      if (!ends) begin
         sha_absorb(d);
         byte_total = byte_total + 61'd4;
         return;
      end
      if (nb > 3'd4) nb = 3'd4;
      byte_total = byte_total + 61'(nb);
      if (nb == 3'd4) begin
         sha_absorb(d);
         sha_absorb(32'h8000_0000);
      end else begin
         keep = (nb == 3'd0) ? 32'd0 : (32'hffffffff << (32 - 8 * nb));
         sha_absorb((d & keep) | (32'h80 << (24 - 8 * nb)));
      end
      while (blk_pos != 4'd14) sha_absorb(32'd0);
      bit_len = {byte_total, 3'b000};
      sha_absorb(bit_len[63:32]);
      sha_absorb(bit_len[31:0]);
      for (int k = 0; k < 8; k++) begin
         beat.word  = known ? ref_digest[255 - 32 * k -: 32] : run_hash[k];
         beat.index = 3'(k);
         beat.last  = (k == 7);
         digest_due.push_back(beat);
      end
      hash_restart();
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap(input logic calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'hffffffff;
         1: return 32'h00000000;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_word(input logic [31:0] d, input logic [2:0] nb, input logic ends,
                            input logic known, input logic [255:0] ref_digest);
      int gap;
      gap = pick_gap(calm_send);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= d;
      req_valid_bytes <= nb;
      req_message_end <= ends;
      do @(posedge clock); while (!req_ready);
      digest_predict(d, nb, ends, known, ref_digest);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_digests();
      while (digest_due.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin : digest_check
      digest_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_due.size() == 0) begin
            $display("%0t: unexpected digest beat, expected none, got word %h index %0d last %b",
                     $time, rsp_digest_word, rsp_word_index, rsp_last_word);
            mismatch_count++;
         end else begin
            want = digest_due.pop_front();
            if (rsp_digest_word !== want.word) begin
               $display("%0t: digest word mismatch, expected %h, got %h",
                        $time, want.word, rsp_digest_word);
               mismatch_count++;
            end
            if (rsp_word_index !== want.index) begin
               $display("%0t: word index mismatch, expected %0d, got %0d",
                        $time, want.index, rsp_word_index);
               mismatch_count++;
            end
            if (rsp_last_word !== want.last) begin
               $display("%0t: last word flag mismatch, expected %b, got %b",
                        $time, want.last, rsp_last_word);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : rsp_stalls
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         hold = ($urandom_range(0, 3) == 0) ? 0 : pick_gap(1'b0);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int pick;
      int body;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_word   = '0;
      req_valid_bytes = '0;
      req_message_end = 1'b0;
      hash_restart();
      for (int i = 0; i < 16; i++) sched[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].data, dir_rows[i].nbytes, dir_rows[i].ends,
                   dir_rows[i].known, dir_rows[i].digest);

      // hold off until the core has handed back everything
      req_valid <= 1'b0;
      drain_digests();

      while (items_sent < 470) begin
         calm_send = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            drain_digests();
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) body = $urandom_range(0, 15);
         else if (pick < 9) body = $urandom_range(12, 18);
         else body = $urandom_range(30, 70);
         repeat (body) send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
         send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      end

      req_valid <= 1'b0;
      drain_digests();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
